// ----- rtl/mfbm_pkg.sv -----
package mfbm_pkg;

  localparam int CHANNELS = 4;
  localparam int TAPS     = 256;

  // input field widths
  localparam int CHAN_W   = 2;
  localparam int TAPIN_W  = 8;
  localparam int COEF_W   = 18;
  localparam int SMP_W    = 16;
  localparam int S_DATA_W = 48;  // 45 payload bits padded to whole bytes

  // output field widths
  localparam int OUT_W    = 16;
  localparam int CLIP_W   = 2;
  localparam int M_DATA_W = 2 * OUT_W;

  // datapath widths
  localparam int PROD_W   = SMP_W + COEF_W;
  localparam int PART_W   = 48;

  // derived storage widths
  localparam int TW       = $clog2(TAPS);
  localparam int HDEPTH   = CHANNELS * TAPS;
  localparam int HA_W     = $clog2(HDEPTH);
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W    = (CH_W > CHAN_W) ? CH_W : CHAN_W;
  localparam int TAPW_W   = 2 * COEF_W;  // {right, left} per tap entry

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam logic EAR_LEFT    = 1'b0;

  typedef struct packed {
    logic issue;        // read issued this cycle
    logic acc_clear;
    logic part_update;  // fold accumulators into partials
    logic part_clear;
  } mac_ctl_t;

  typedef struct packed {
    logic             clip;
    logic [OUT_W-1:0] value;
  } q15_t;

  // row * TAPS + idx, row is a channel number
  function automatic logic [HA_W-1:0] row_addr(input logic [ROW_W-1:0] row,
                                               input logic [TW-1:0] idx);
    logic [HA_W+ROW_W:0] full;
    full = (HA_W+ROW_W+1)'(row) * (HA_W+ROW_W+1)'(TAPS) + (HA_W+ROW_W+1)'(idx);
    return full[HA_W-1:0];
  endfunction

  // round Q.30 partial to Q1.15 and clamp
  function automatic q15_t to_q15(input logic signed [PART_W-1:0] part);
    logic signed [PART_W:0]    biased;
    logic signed [PART_W-15:0] shifted;
    q15_t                      res;
    biased  = (PART_W+1)'(part) + (PART_W+1)'(16384);
    shifted = biased[PART_W:15];
    if (shifted > (PART_W-14)'(32767)) begin
      res.value = 16'h7fff;
      res.clip  = 1'b1;
    end else if (shifted < -(PART_W-14)'(32768)) begin
      res.value = 16'h8000;
      res.clip  = 1'b1;
    end else begin
      res.value = shifted[OUT_W-1:0];
      res.clip  = 1'b0;
    end
    return res;
  endfunction

endpackage

// ----- rtl/mfbm_ram.sv -----
module mfbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mfbm_mac.sv -----
module mfbm_mac (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mfbm_pkg::mac_ctl_t                      ctl,
  input  logic [mfbm_pkg::SMP_W-1:0]              hist_rd,
  input  logic [mfbm_pkg::TAPW_W-1:0]             tap_rd,
  output logic                                    busy,
  output logic signed [mfbm_pkg::PART_W-1:0]      left_partial,
  output logic signed [mfbm_pkg::PART_W-1:0]      right_partial
);
  import mfbm_pkg::*;

  localparam logic signed [PART_W:0] PMAX = (PART_W+1)'({1'b0, {(PART_W-1){1'b1}}});
  localparam logic signed [PART_W:0] PMIN = -PMAX - (PART_W+1)'(1);

  function automatic logic signed [PART_W-1:0] sat_add(input logic signed [PART_W-1:0] a,
                                                      input logic signed [PART_W-1:0] b);
    logic signed [PART_W:0] s;
    s = (PART_W+1)'(a) + (PART_W+1)'(b);
    if (s > PMAX) begin
      return PMAX[PART_W-1:0];
    end else if (s < PMIN) begin
      return PMIN[PART_W-1:0];
    end
    return s[PART_W-1:0];
  endfunction

  logic                     v1, v2;
  logic signed [PROD_W-1:0] prod_l, prod_r;
  logic signed [PART_W-1:0] acc_l, acc_r;

  assign busy = v1 | v2;

  // stage 1: product of history word and both ear taps
  always_ff @(posedge clk) begin
    if (v1) begin
      prod_l <= $signed(hist_rd) * $signed(tap_rd[COEF_W-1:0]);
      prod_r <= $signed(hist_rd) * $signed(tap_rd[TAPW_W-1:COEF_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      acc_l         <= '0;
      acc_r         <= '0;
      left_partial  <= '0;
      right_partial <= '0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      // stage 2: accumulate
      if (ctl.acc_clear) begin
        acc_l <= '0;
        acc_r <= '0;
      end else if (v2) begin
        acc_l <= acc_l + PART_W'(prod_l);
        acc_r <= acc_r + PART_W'(prod_r);
      end
      if (ctl.part_clear) begin
        left_partial  <= '0;
        right_partial <= '0;
      end else if (ctl.part_update) begin
        left_partial  <= sat_add(left_partial, acc_l);
        right_partial <= sat_add(right_partial, acc_r);
      end
    end
  end

endmodule

// ----- rtl/multichannel_fir_binaural_mixdown.sv -----
// Multichannel FIR binaural mixdown.
// Input stream (s_axis_*): one transaction per channel sample or per
// coefficient write. tuser selects the kind (0 coefficient, 1 sample),
// tlast marks the last channel sample of a frame.
// Output stream (m_axis_*): one stereo Q1.15 sample per frame, emitted by
// the sample transaction that carries tlast; tuser carries the clip flags.
// Sequence: a coefficient write is a read-modify-write of the packed
// left/right tap word. A sample goes through the single history read port:
// one tap per cycle for both ears, plus the history write, two pipeline
// stages and the partial update. A frame end then loads the output
// register and zeroes the next history slot of every channel.
// Reset: the history memory is cleared by a sweep over all CHANNELS * TAPS
// entries (1024 here); s_axis_tready stays low until it ends. Taps are
// undefined until written.
// Stall: the result sits in an output register; the block keeps taking and
// processing items and only waits when the next result is ready while the
// previous one has not been taken.
module multichannel_fir_binaural_mixdown (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // channel[1:0], ear[2], tap[10:3], coefficient[28:11], sample[44:29], zero pad
  input  logic [mfbm_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // kind[0]
  input  logic                            s_axis_tuser,
  // frame_end
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // left_out[15:0], right_out[31:16]
  output logic [mfbm_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // clip_flags[1:0]
  output logic [mfbm_pkg::CLIP_W-1:0]     m_axis_tuser
);
  import mfbm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CLEAR = 10'b00_0000_0010,  // reset sweep of history memory
    S_CRD   = 10'b00_0000_0100,  // coefficient: read packed tap word
    S_CWR   = 10'b00_0000_1000,  // coefficient: merge and write back
    S_HWR   = 10'b00_0001_0000,  // sample: store into history
    S_MAC   = 10'b00_0010_0000,  // issue one tap read per cycle
    S_DRAIN = 10'b00_0100_0000,  // wait for MAC pipeline
    S_SUM   = 10'b00_1000_0000,  // fold into partials
    S_EMIT  = 10'b01_0000_0000,  // load output register
    S_ZERO  = 10'b10_0000_0000   // zero next slot of every channel
  } state_t;

  state_t state, state_next;

  // captured transaction
  logic [CHAN_W-1:0]        it_ch;
  logic                     it_ear;
  logic [TW-1:0]            it_tap;
  logic [COEF_W-1:0]        it_coef;
  logic [SMP_W-1:0]         it_smp;
  logic                     it_fend;

  logic [TW-1:0]            ptr;       // history slot of current frame
  logic [TW-1:0]            tcnt;      // tap index
  logic [TW-1:0]            hidx;      // history index, walks backwards
  logic [HA_W-1:0]          clr_addr;
  logic [CH_W-1:0]          zc;

  logic                     s_acc;
  logic                     ch_ok, tap_ok;
  logic                     emit_go;

  logic                     h_we;
  logic [HA_W-1:0]          h_waddr, h_raddr;
  logic [SMP_W-1:0]         h_wdata, h_rdata;
  logic                     t_we;
  logic [HA_W-1:0]          t_addr, t_raddr;
  logic [TAPW_W-1:0]        t_wdata, t_rdata;

  mac_ctl_t                 mctl;
  logic                     mac_busy;
  logic signed [PART_W-1:0] lpart, rpart;
  q15_t                     lq, rq;

  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign ch_ok         = int'(s_axis_tdata[1:0]) < CHANNELS;
  assign tap_ok        = int'(s_axis_tdata[10:3]) < TAPS;
  assign emit_go       = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (s_acc) begin
      it_ch   <= s_axis_tdata[1:0];
      it_ear  <= s_axis_tdata[2];
      it_tap  <= TW'(s_axis_tdata[10:3]);
      it_coef <= s_axis_tdata[28:11];
      it_smp  <= s_axis_tdata[44:29];
      it_fend <= s_axis_tlast;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser == KIND_COEF) begin
            state_next = (ch_ok && tap_ok) ? S_CRD : S_IDLE;
          end else if (ch_ok) begin
            state_next = S_HWR;
          end else begin
            state_next = s_axis_tlast ? S_EMIT : S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        if (clr_addr == HA_W'(HDEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_CRD:   state_next = S_CWR;
      S_CWR:   state_next = S_IDLE;
      S_HWR:   state_next = S_MAC;
      S_MAC: begin
        if (tcnt == TW'(TAPS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_next = S_SUM;
        end
      end
      S_SUM:   state_next = it_fend ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (emit_go) begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (zc == CH_W'(CHANNELS - 1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      ptr      <= '0;
      tcnt     <= '0;
      hidx     <= '0;
      zc       <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_HWR) begin
        tcnt <= '0;
        hidx <= ptr;
      end
      if (state == S_MAC) begin
        tcnt <= tcnt + 1'b1;
        hidx <= (hidx == '0) ? TW'(TAPS - 1) : hidx - 1'b1;
      end
      if (state == S_EMIT && emit_go) begin
        ptr <= (ptr == TW'(TAPS - 1)) ? '0 : ptr + 1'b1;
        zc  <= '0;
      end
      if (state == S_ZERO) begin
        zc <= zc + 1'b1;
      end
    end
  end

  // history memory ports
  always_comb begin
    h_we    = 1'b0;
    h_waddr = row_addr(ROW_W'(it_ch), ptr);
    h_wdata = '0;
    unique case (1'b1)
      (state == S_CLEAR): begin
        h_we    = 1'b1;
        h_waddr = clr_addr;
      end
      (state == S_HWR): begin
        h_we    = 1'b1;
        h_wdata = it_smp;
      end
      (state == S_ZERO): begin
        h_we    = 1'b1;
        h_waddr = row_addr(ROW_W'(zc), ptr);
      end
      default: h_we = 1'b0;
    endcase
  end
  assign h_raddr = row_addr(ROW_W'(it_ch), hidx);

  // tap memory: {right, left} per entry, coefficient write is read-modify-write
  assign t_addr  = row_addr(ROW_W'(it_ch), it_tap);
  assign t_raddr = (state == S_MAC) ? row_addr(ROW_W'(it_ch), tcnt) : t_addr;
  assign t_we    = (state == S_CWR);
  assign t_wdata = (it_ear == EAR_LEFT) ? {t_rdata[TAPW_W-1:COEF_W], it_coef}
                                        : {it_coef, t_rdata[COEF_W-1:0]};

  mfbm_ram #(.WIDTH(SMP_W), .DEPTH(HDEPTH)) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  mfbm_ram #(.WIDTH(TAPW_W), .DEPTH(HDEPTH)) u_taps (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_addr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  always_comb begin
    mctl.issue       = (state == S_MAC);
    mctl.acc_clear   = (state == S_HWR);
    mctl.part_update = (state == S_SUM);
    mctl.part_clear  = (state == S_EMIT) && emit_go;
  end

  mfbm_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .ctl           (mctl),
    .hist_rd       (h_rdata),
    .tap_rd        (t_rdata),
    .busy          (mac_busy),
    .left_partial  (lpart),
    .right_partial (rpart)
  );

  // output register
  assign lq = to_q15(lpart);
  assign rq = to_q15(rpart);

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      m_axis_tdata <= {rq.value, lq.value};
      m_axis_tuser <= {rq.clip, lq.clip};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(m_axis_tvalid) |-> $past(state == S_EMIT))
    else $error("output valid rose outside emit");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_SUM |-> !mac_busy)
    else $error("partials folded with products in flight");

  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(ptr) |-> $past(state == S_EMIT))
    else $error("history pointer moved outside frame end");

  a_no_wr_mac: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC || state == S_DRAIN |-> !h_we && !t_we)
    else $error("memory write during convolution");
`endif

endmodule

// ----- dv/tb_multichannel_fir_binaural_mixdown.sv -----
module tb_multichannel_fir_binaural_mixdown;
  import mfbm_pkg::*;

  localparam logic EAR_RIGHT = ~EAR_LEFT;

  localparam int COEF_MAX = 2 ** (COEF_W - 1) - 1;
  localparam int COEF_MIN = -(2 ** (COEF_W - 1));
  localparam int SMP_MAX  = 2 ** (SMP_W - 1) - 1;
  localparam int SMP_MIN  = -(2 ** (SMP_W - 1));

  localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  // channels whose taps are all written and that carry samples
  localparam int LIVE_CHANNELS = 2;
  localparam int RANDOM_ITEMS  = 200;
  // partial saturation: full-scale taps span, length of the long frame
  localparam int SAT_SPAN      = 128;
  localparam int SAT_LONG      = 300;
  localparam int DRAIN_CYCLES  = 4 * TAPS;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int MAX_REPORTS   = 10;

  // one input transaction, unpacked to fields
  typedef struct packed {
    logic                     kind;
    logic [CHAN_W-1:0]        channel;
    logic                     ear;
    logic [TAPIN_W-1:0]       tap;
    logic signed [COEF_W-1:0] coef;
    logic signed [SMP_W-1:0]  sample;
    logic                     frame_end;
  } mix_item_t;

  // one stereo output transaction
  typedef struct packed {
    logic [OUT_W-1:0]  left;
    logic [OUT_W-1:0]  right;
    logic [CLIP_W-1:0] clip;
  } stereo_t;

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [CLIP_W-1:0]     m_axis_tuser;

  multichannel_fir_binaural_mixdown dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // stimulus and expectations
  mix_item_t pending_items[$];
  stereo_t   stereo_expected[$];
  mix_item_t on_bus;
  stereo_t   want;
  int        total_items = 1;
  int        n_accepted  = 0;
  int        idle_phase  = 0;
  int        n_fail      = 0;

  // idle percentages per phase: sender-heavy, receiver-heavy, none
  int send_idle[3] = '{33, 72, 0};
  int recv_idle[3] = '{72, 33, 0};

  // mirror of the block state
  logic signed [SMP_W-1:0]  hist_mem [CHANNELS][TAPS];
  logic signed [COEF_W-1:0] coef_mem [CHANNELS][2][TAPS];
  int unsigned              hist_slot;
  longint                   left_acc;
  longint                   right_acc;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void note_failure(input string msg);
    if (n_fail < MAX_REPORTS) $display("ERROR: %s", msg);
    n_fail++;
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // Q.30 -> Q1.15, round half up, clamp
  function automatic void q15_round(input longint acc, output logic [OUT_W-1:0] v,
                                    output logic clipped);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    clipped = 1'b0;
    if (r > SMP_MAX) begin
      r = SMP_MAX;
      clipped = 1'b1;
    end else if (r < SMP_MIN) begin
      r = SMP_MIN;
      clipped = 1'b1;
    end
    v = OUT_W'(r);
  endfunction

  // apply one accepted transaction; queue the stereo sample on frame end
  function automatic void mixdown_step(input mix_item_t it);
    longint      lsum;
    longint      rsum;
    int unsigned idx;
    stereo_t     res;
    logic        lclip;
    logic        rclip;
    if (it.kind == KIND_COEF) begin
      if (it.channel < CHANNELS && it.tap < TAPS)
        coef_mem[it.channel][it.ear][it.tap] = it.coef;
      return;
    end
    if (it.channel < CHANNELS) begin
      hist_mem[it.channel][hist_slot] = it.sample;
      lsum = 0;
      rsum = 0;
      for (int t = 0; t < TAPS; t++) begin
        idx = (hist_slot + TAPS - t) % TAPS;
        lsum += longint'(hist_mem[it.channel][idx]) *
                longint'(coef_mem[it.channel][EAR_LEFT][t]);
        rsum += longint'(hist_mem[it.channel][idx]) *
                longint'(coef_mem[it.channel][EAR_RIGHT][t]);
      end
      left_acc  = clamp48(left_acc + lsum);
      right_acc = clamp48(right_acc + rsum);
    end
    if (!it.frame_end) return;
    q15_round(left_acc, res.left, lclip);
    q15_round(right_acc, res.right, rclip);
    res.clip = {rclip, lclip};
    stereo_expected.insert(stereo_expected.size(), res);
    left_acc  = 0;
    right_acc = 0;
    hist_slot = (hist_slot + 1) % TAPS;
    for (int c = 0; c < CHANNELS; c++) hist_mem[c][hist_slot] = '0;
  endfunction

  // mostly zero taps so the sums clip now and then, not always
  function automatic int rand_coef();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 78) return 0;
    if (r < 93) return int'($urandom_range(2048)) - 1024;
    if (r < 98) return int'($urandom_range(32768)) - 16384;
    if (r < 99) return $urandom_range(1) ? COEF_MAX : COEF_MIN;
    return int'($urandom_range(COEF_MAX - COEF_MIN)) + COEF_MIN;
  endfunction

  function automatic int rand_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return int'($urandom_range(SMP_MAX - SMP_MIN)) + SMP_MIN;
    if (r < 70) return int'($urandom_range(1024)) - 512;
    if (r < 85) begin
      case ($urandom_range(3))
        0: return SMP_MAX;
        1: return SMP_MIN;
        2: return 0;
        default: return -1;
      endcase
    end
    return int'($urandom_range(16384)) - 8192;
  endfunction

  // unused fields carry random noise
  task automatic push_coef(input int ch, input logic ear, input int tap, input int coef,
                           input logic fend);
    mix_item_t it;
    it.kind      = KIND_COEF;
    it.channel   = CHAN_W'(ch);
    it.ear       = ear;
    it.tap       = TAPIN_W'(tap);
    it.coef      = COEF_W'(coef);
    it.sample    = SMP_W'($urandom);
    it.frame_end = fend;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_sample(input int ch, input int smp, input logic fend);
    mix_item_t it;
    it.kind      = KIND_SAMPLE;
    it.channel   = CHAN_W'(ch);
    it.ear       = 1'($urandom);
    it.tap       = TAPIN_W'($urandom);
    it.coef      = COEF_W'($urandom);
    it.sample    = SMP_W'(smp);
    it.frame_end = fend;
    pending_items.insert(pending_items.size(), it);
  endtask

  // write every tap of one channel, both ears
  task automatic load_taps(input int ch);
    for (int t = 0; t < TAPS; t++) begin
      push_coef(ch, EAR_LEFT, t, rand_coef(), $urandom_range(7) == 0);
      push_coef(ch, EAR_RIGHT, t, rand_coef(), $urandom_range(7) == 0);
    end
  endtask

  // driver: presents queued items, predicts each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        mixdown_step(on_bus);
        n_accepted++;
        idle_phase = (n_accepted * 3) / total_items;
        if (idle_phase > 2) idle_phase = 2;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle[idle_phase]) begin
          on_bus = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_DATA_W'({on_bus.sample, on_bus.coef, on_bus.tap, on_bus.ear,
                                      on_bus.channel});
          s_axis_tuser  <= on_bus.kind;
          s_axis_tlast  <= on_bus.frame_end;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, checks every output transaction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (stereo_expected.size() == 0) begin
          note_failure($sformatf("unexpected output L=%0d R=%0d clip=%0d",
                                 $signed(m_axis_tdata[OUT_W-1:0]),
                                 $signed(m_axis_tdata[2*OUT_W-1:OUT_W]), m_axis_tuser));
        end else begin
          want = stereo_expected.pop_front();
          if (m_axis_tdata[OUT_W-1:0] !== want.left ||
              m_axis_tdata[2*OUT_W-1:OUT_W] !== want.right ||
              m_axis_tuser !== want.clip)
            note_failure($sformatf("mismatch: expected L=%0d R=%0d clip=%0d, got L=%0d R=%0d clip=%0d",
                                   $signed(want.left), $signed(want.right), want.clip,
                                   $signed(m_axis_tdata[OUT_W-1:0]),
                                   $signed(m_axis_tdata[2*OUT_W-1:OUT_W]), m_axis_tuser));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle[idle_phase]);
    end
  end

  // reset release, then watchdog
  initial begin
    int cycles;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("multichannel_fir_binaural_mixdown regression: fail");
    $finish;
  end

  initial begin
    int n;
    int len;
    int unsigned pick;

    for (int c = 0; c < CHANNELS; c++) begin
      for (int t = 0; t < TAPS; t++) begin
        hist_mem[c][t]    = '0;
        coef_mem[c][0][t] = '0;
        coef_mem[c][1][t] = '0;
      end
    end
    hist_slot = 0;
    left_acc  = 0;
    right_acc = 0;

    // taps are undefined until written: every sample reads all taps of its
    // channel, so fill the taps of every channel that carries samples first
    for (int c = 0; c < LIVE_CHANNELS; c++) load_taps(c);

    // directed: extremes, frame end on coefficient write, channel gaps and repeats
    push_coef(0, EAR_LEFT, 0, COEF_MAX, 1'b1);
    push_coef(1, EAR_RIGHT, TAPS - 1, COEF_MIN, 1'b0);
    push_coef(3, EAR_RIGHT, 0, COEF_MIN, 1'b1);
    push_sample(0, SMP_MAX, 1'b0);
    push_sample(1, SMP_MIN, 1'b1);
    push_sample(0, SMP_MIN, 1'b1);      // other channel absent
    push_sample(1, 1000, 1'b0);         // channel 1 twice
    push_sample(1, SMP_MIN, 1'b0);
    push_sample(0, SMP_MAX, 1'b1);
    push_sample(1, 0, 1'b1);            // zero sample
    push_coef(1, EAR_LEFT, 1, COEF_MAX, 1'b0);
    push_coef(1, EAR_RIGHT, 1, COEF_MAX, 1'b0);
    push_sample(1, SMP_MAX, 1'b0);
    push_sample(1, SMP_MAX, 1'b1);
    push_coef(0, EAR_RIGHT, TAPS - 1, 1, 1'b0);
    push_sample(0, SMP_MIN, 1'b1);

    // random: mostly full frames, some odd frames, stray samples and tap writes
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        push_coef($urandom_range(CHANNELS - 1), 1'($urandom), $urandom_range(TAPS - 1),
                  rand_coef(), $urandom_range(4) == 0);
        n++;
      end else if (pick < 17) begin
        push_sample($urandom_range(LIVE_CHANNELS - 1), rand_sample(), 1'($urandom));
        n++;
      end else if (pick < 35) begin
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++)
          push_sample($urandom_range(LIVE_CHANNELS - 1), rand_sample(), k == len - 1);
        n += len;
      end else begin
        for (int c = 0; c < LIVE_CHANNELS; c++)
          push_sample(c, rand_sample(), c == LIVE_CHANNELS - 1);
        n += LIVE_CHANNELS;
      end
    end

    // partial saturation, last since it leaves full-scale taps behind:
    // full-scale taps on the first SAT_SPAN taps of channel 1, frames that
    // fill that much history with full-scale samples, then one long frame
    // that drives both ear sums past the 48-bit range
    for (int t = 0; t < SAT_SPAN; t++) begin
      push_coef(1, EAR_LEFT, t, COEF_MIN, 1'b0);
      push_coef(1, EAR_RIGHT, t, COEF_MAX, 1'b0);
    end
    for (int i = 0; i < SAT_SPAN - 1; i++) push_sample(1, SMP_MIN, 1'b1);
    for (int i = 0; i < SAT_LONG; i++) push_sample(1, SMP_MIN, i == SAT_LONG - 1);
    total_items = pending_items.size();

    while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (stereo_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (stereo_expected.size() != 0)
      note_failure($sformatf("%0d stereo samples never arrived", stereo_expected.size()));
    if (n_fail == 0) begin
      $display("multichannel_fir_binaural_mixdown regression: pass");
    end else begin
      $display("multichannel_fir_binaural_mixdown regression: fail");
    end
    $finish;
  end

endmodule
